### rtl/btff_pkg.sv
// Package for the boundary-tag first-fit allocator.
// Holds the request and response item types, status codes and sequencer states.
// No dependencies.
package btff_pkg;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_NOFIT   = 2'd1;
  localparam logic [1:0] STATUS_IGNORED = 2'd2;

  localparam int unsigned POOL_RESET = 16384;
  localparam int unsigned POOL_MIN   = 8;
  localparam int unsigned MIN_FRAG   = 3;
  localparam int unsigned TAG_WORDS  = 2;

  typedef struct packed {
    logic        req_type;
    logic [16:0] request_bytes;
    logic [13:0] payload_word;
  } btff_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] granted_word;
    logic [13:0] fragment_count;
    logic [13:0] free_fragment_count;
    logic [14:0] free_word_count;
  } btff_rsp_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_A_SPLIT,
    ST_F_RD,
    ST_F_CHK,
    ST_R_RD,
    ST_R_CHK,
    ST_LEFT,
    ST_FIN
  } btff_state_t;

endpackage

### rtl/btff_tag_ram.sv
// Single-port tag store: one synchronous read or write per cycle.
// Read data is registered. No package dependencies.
module btff_tag_ram #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14,
  parameter int TW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [TW-1:0] wdata,
  output logic [TW-1:0] rdata
);

  logic [TW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/btff_ctrl.sv
// Sequencer for the allocator: walks the fragment chain in the tag store,
// performs allocate/free updates and keeps the pool counters. Uses btff_pkg.
module btff_ctrl #(
  parameter int POOL_WORDS_MAX = 16384,
  parameter int AW             = 14,
  parameter int PW             = 15,
  parameter int XW             = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  btff_pkg::btff_req_t req,
  input  logic              cfg_valid,
  input  logic [14:0]       cfg_data,
  output logic              res_valid,
  input  logic              res_ready,
  output btff_pkg::btff_rsp_t res,
  output logic              mem_we,
  output logic [AW-1:0]     mem_addr,
  output logic [PW:0]       mem_wdata,
  input  logic [PW:0]       mem_rdata
);

  localparam logic [XW-1:0] POOL_HI  = XW'(POOL_WORDS_MAX);
  localparam logic [XW-1:0] POOL_LO  = XW'(btff_pkg::POOL_MIN);
  localparam logic [XW-1:0] POOL_RST = (XW'(btff_pkg::POOL_RESET) < POOL_HI) ?
                                       XW'(btff_pkg::POOL_RESET) : POOL_HI;
  localparam logic [XW-1:0] MIN_FRAG = XW'(btff_pkg::MIN_FRAG);
  localparam logic [XW-1:0] TAGS     = XW'(btff_pkg::TAG_WORDS);

  btff_pkg::btff_state_t state, state_next;

  logic [XW-1:0] pool, pool_next;
  logic [XW-1:0] cur, cur_next;
  logic [XW-1:0] head, head_next;
  logic [XW-1:0] words, words_next;
  logic [XW-1:0] s, s_next;
  logic [XW-1:0] prev, prev_next;
  logic [XW-1:0] prev_size, prev_size_next;
  logic          prev_free, prev_free_next;
  logic          has_prev, has_prev_next;
  logic [XW-1:0] frag, frag_next;
  logic [XW-1:0] ffrag, ffrag_next;
  logic [XW-1:0] fwords, fwords_next;
  logic [XW-1:0] granted, granted_next;
  logic [1:0]    status, status_next;

  logic [XW-1:0] rsz;
  logic          rfree;
  logic [XW-1:0] req_words;
  logic [XW-1:0] rem;
  logic [XW-1:0] nxt;
  logic [XW-1:0] cfg_v;

  assign rsz       = XW'(mem_rdata[PW-1:0]);
  assign rfree     = mem_rdata[PW];
  assign req_words = XW'(req.request_bytes[16:2]) + XW'(|req.request_bytes[1:0]);
  assign rem       = rsz - TAGS - words;
  assign nxt       = head + s;

  always_comb begin
    cfg_v = XW'(cfg_data);
    if (cfg_v < POOL_LO) begin
      cfg_v = POOL_LO;
    end
    if (cfg_v > POOL_HI) begin
      cfg_v = POOL_HI;
    end
  end

  assign req_stall = (state != btff_pkg::ST_IDLE);

  always_comb begin
    state_next     = state;
    pool_next      = pool;
    cur_next       = cur;
    head_next      = head;
    words_next     = words;
    s_next         = s;
    prev_next      = prev;
    prev_size_next = prev_size;
    prev_free_next = prev_free;
    has_prev_next  = has_prev;
    frag_next      = frag;
    ffrag_next     = ffrag;
    fwords_next    = fwords;
    granted_next   = granted;
    status_next    = status;
    mem_we         = 1'b0;
    mem_addr       = cur[AW-1:0];
    mem_wdata      = '0;
    res_valid      = 1'b0;
    case (state)
      btff_pkg::ST_INIT: begin
        // only head tags are ever read back, so format writes word 0 alone
        mem_we      = 1'b1;
        mem_addr    = '0;
        mem_wdata   = {1'b1, pool[PW-1:0]};
        frag_next   = XW'(1);
        ffrag_next  = XW'(1);
        fwords_next = pool - TAGS;
        state_next  = btff_pkg::ST_IDLE;
      end
      btff_pkg::ST_IDLE: begin
        if (req_valid) begin
          granted_next  = '0;
          cur_next      = '0;
          has_prev_next = 1'b0;
          if (req.req_type) begin
            if (req.payload_word == '0) begin
              status_next = btff_pkg::STATUS_IGNORED;
              state_next  = btff_pkg::ST_FIN;
            end else begin
              head_next  = XW'(req.payload_word) - XW'(1);
              state_next = btff_pkg::ST_F_RD;
            end
          end else begin
            words_next = req_words;
            if (req_words == '0) begin
              status_next = btff_pkg::STATUS_NOFIT;
              state_next  = btff_pkg::ST_FIN;
            end else begin
              state_next = btff_pkg::ST_A_RD;
            end
          end
        end
      end
      btff_pkg::ST_A_RD: begin
        if (cur >= pool) begin
          status_next = btff_pkg::STATUS_NOFIT;
          state_next  = btff_pkg::ST_FIN;
        end else begin
          state_next = btff_pkg::ST_A_CHK;
        end
      end
      btff_pkg::ST_A_CHK: begin
        if (rsz < MIN_FRAG) begin
          status_next = btff_pkg::STATUS_NOFIT;
          state_next  = btff_pkg::ST_FIN;
        end else if (rfree && (words <= rsz - TAGS)) begin
          granted_next = cur + XW'(1);
          status_next  = btff_pkg::STATUS_DONE;
          mem_we       = 1'b1;
          if (rem < MIN_FRAG) begin
            // exact fit or absorb the short remainder
            mem_wdata   = {1'b0, rsz[PW-1:0]};
            ffrag_next  = ffrag - XW'(1);
            fwords_next = (rem == '0) ? fwords - words : fwords - (rsz - TAGS);
            state_next  = btff_pkg::ST_FIN;
          end else begin
            mem_wdata   = {1'b0, PW'(words + TAGS)};
            fwords_next = fwords - (words + TAGS);
            frag_next   = frag + XW'(1);
            s_next      = rem;
            state_next  = btff_pkg::ST_A_SPLIT;
          end
        end else begin
          cur_next   = cur + rsz;
          state_next = btff_pkg::ST_A_RD;
        end
      end
      btff_pkg::ST_A_SPLIT: begin
        mem_we     = 1'b1;
        mem_addr   = AW'(cur + words + TAGS);
        mem_wdata  = {1'b1, s[PW-1:0]};
        state_next = btff_pkg::ST_FIN;
      end
      btff_pkg::ST_F_RD: begin
        if (cur >= pool) begin
          status_next = btff_pkg::STATUS_IGNORED;
          state_next  = btff_pkg::ST_FIN;
        end else begin
          state_next = btff_pkg::ST_F_CHK;
        end
      end
      btff_pkg::ST_F_CHK: begin
        if (rsz < MIN_FRAG || cur > head || (cur == head && rfree)) begin
          status_next = btff_pkg::STATUS_IGNORED;
          state_next  = btff_pkg::ST_FIN;
        end else if (cur == head) begin
          s_next      = rsz;
          ffrag_next  = ffrag + XW'(1);
          fwords_next = fwords + rsz - TAGS;
          state_next  = btff_pkg::ST_R_RD;
        end else begin
          // remember the left neighbor for the final merge
          prev_next      = cur;
          prev_size_next = rsz;
          prev_free_next = rfree;
          has_prev_next  = 1'b1;
          cur_next       = cur + rsz;
          state_next     = btff_pkg::ST_F_RD;
        end
      end
      btff_pkg::ST_R_RD: begin
        mem_addr = nxt[AW-1:0];
        if (nxt >= pool) begin
          state_next = btff_pkg::ST_LEFT;
        end else begin
          state_next = btff_pkg::ST_R_CHK;
        end
      end
      btff_pkg::ST_R_CHK: begin
        if (!rfree || rsz < MIN_FRAG) begin
          state_next = btff_pkg::ST_LEFT;
        end else begin
          s_next      = s + rsz;
          frag_next   = frag - XW'(1);
          ffrag_next  = ffrag - XW'(1);
          fwords_next = fwords + TAGS;
          state_next  = btff_pkg::ST_R_RD;
        end
      end
      btff_pkg::ST_LEFT: begin
        mem_we      = 1'b1;
        status_next = btff_pkg::STATUS_DONE;
        if (has_prev && prev_free) begin
          mem_addr    = prev[AW-1:0];
          mem_wdata   = {1'b1, PW'(prev_size + s)};
          frag_next   = frag - XW'(1);
          ffrag_next  = ffrag - XW'(1);
          fwords_next = fwords + TAGS;
        end else begin
          mem_addr  = head[AW-1:0];
          mem_wdata = {1'b1, s[PW-1:0]};
        end
        state_next = btff_pkg::ST_FIN;
      end
      btff_pkg::ST_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = btff_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = btff_pkg::ST_INIT;
      end
    endcase
    if (cfg_valid) begin
      pool_next  = cfg_v;
      state_next = btff_pkg::ST_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btff_pkg::ST_INIT;
      pool  <= POOL_RST;
    end else begin
      state <= state_next;
      pool  <= pool_next;
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    head      <= head_next;
    words     <= words_next;
    s         <= s_next;
    prev      <= prev_next;
    prev_size <= prev_size_next;
    prev_free <= prev_free_next;
    has_prev  <= has_prev_next;
    frag      <= frag_next;
    ffrag     <= ffrag_next;
    fwords    <= fwords_next;
    granted   <= granted_next;
    status    <= status_next;
  end

  assign res.status              = status;
  assign res.granted_word        = granted[13:0];
  assign res.fragment_count      = frag[13:0];
  assign res.free_fragment_count = ffrag[13:0];
  assign res.free_word_count     = fwords[14:0];

  // prev is kept for address only; the walk never revisits it
endmodule

### rtl/boundary_tag_first_fit_allocator.sv
// Boundary-tag first-fit allocator over a pool of 4-byte words.
// Request channel (req_valid/req_stall/req): an item is taken when req_valid is
// high and req_stall low. req_type 0 allocates request_bytes, 1 frees the
// fragment whose payload starts at payload_word.
// Response channel (rsp_valid/rsp_stall/rsp): one item per request carrying the
// status, the granted payload word and the pool counters after the request.
// Configuration channel (cfg_valid/cfg_ready/cfg_data): writes the pool size in
// words (saturated to 8..POOL_WORDS_MAX) and reformats the pool as one free
// fragment; write it only while no request is in flight.
// An allocate reads head tags along the chain from word 0 until a free fragment
// fits, then writes its head tag, plus the remainder's tag on a split; a walk
// that runs off the pool end reports no fit. A free walks to the fragment,
// merges free right neighbors, then writes the merged tag at the left neighbor
// if it is free, else at the fragment. Null and zero-size requests go straight
// to the result. Each walk step is one read of the single-port tag store, so the
// chain walk sets the rate; the next request is taken the cycle after the result
// enters the output register. Reset (and each configuration write) formats the
// pool in ST_INIT, with req_stall high. A stalled response holds in the output
// register while the block takes and works on the next request, which holds
// its own result. Uses btff_pkg, btff_ctrl and btff_tag_ram.
module boundary_tag_first_fit_allocator #(
  parameter int POOL_WORDS_MAX = 16384
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  btff_pkg::btff_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output btff_pkg::btff_rsp_t rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [14:0]         cfg_data
);

  localparam int AW = $clog2(POOL_WORDS_MAX);
  localparam int PW = AW + 1;
  localparam int XW = (PW > 17) ? PW : 17;

  logic                res_valid;
  logic                res_ready;
  btff_pkg::btff_rsp_t res;
  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  logic [PW:0]         mem_wdata;
  logic [PW:0]         mem_rdata;

  assign cfg_ready = 1'b1;
  assign res_ready = !rsp_valid || !rsp_stall;

  btff_ctrl #(
    .POOL_WORDS_MAX(POOL_WORDS_MAX),
    .AW            (AW),
    .PW            (PW),
    .XW            (XW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .mem_we   (mem_we),
    .mem_addr (mem_addr),
    .mem_wdata(mem_wdata),
    .mem_rdata(mem_rdata)
  );

  btff_tag_ram #(
    .DEPTH(POOL_WORDS_MAX),
    .AW   (AW),
    .TW   (PW + 1)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == btff_pkg::STATUS_DONE ||
                   rsp.status == btff_pkg::STATUS_NOFIT ||
                   rsp.status == btff_pkg::STATUS_IGNORED))
    else $error("response status out of range");

  a_grant_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.granted_word != '0 |-> rsp.status == btff_pkg::STATUS_DONE)
    else $error("grant reported on a failed request");

  a_free_le_total: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.free_fragment_count <= rsp.fragment_count)
    else $error("more free fragments than fragments");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && !cfg_valid |=> req_stall)
    else $error("request taken while a walk is pending");

endmodule
